// ===== src/tfcc_pkg.sv =====
package tfcc_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SUM_DIR0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SUM_DIR1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_DIR0       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_DIR1       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_START_OFFSET  = 3'd4;

	// Register reset values
	localparam logic [15:0] EXPECTED_SUM_RST = 16'h0000;
	localparam logic [7:0]  MARKER_DIR0_RST  = 8'h10;
	localparam logic [7:0]  MARKER_DIR1_RST  = 8'h40;
	localparam logic [5:0]  SUM_OFFSET_RST   = 6'd18;

	// Frame position tracking
	localparam int          POS_W        = 7;
	localparam logic [6:0]  MARKER_POS   = 7'd6;
	localparam logic [6:0]  POS_MAX      = 7'd127;

	// Direction codes
	localparam logic [1:0] DIR_ZERO = 2'd0;
	localparam logic [1:0] DIR_ONE  = 2'd1;
	localparam logic [1:0] DIR_NONE = 2'd2;

	// Per-frame summary handed from the accumulator to the result logic
	typedef struct packed {
		logic [15:0] sum;      // inverted folded checksum, valid on last byte
		logic        seen;     // first source MAC byte was present
		logic [7:0]  marker;   // value of that byte
	} frame_sum_t;

endpackage

// ===== src/tfcc_frame_acc.sv =====
module tfcc_frame_acc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           frame_byte,
	input  logic                 last_byte,
	input  logic [5:0]           sum_start_offset,
	output tfcc_pkg::frame_sum_t summary
);

	logic [tfcc_pkg::POS_W-1:0] pos_q;
	logic [15:0]                acc_q;
	logic                       odd_q;
	logic [7:0]                 held_q;
	logic [7:0]                 marker_q;
	logic                       seen_q;

	logic        covered;
	logic        at_marker;
	logic        do_add;
	logic [15:0] word;
	logic [16:0] raw_sum;
	logic [15:0] folded;
	logic [15:0] acc_next;

	// Coverage and marker detection for the current byte
	assign covered   = pos_q >= {1'b0, sum_start_offset};
	assign at_marker = pos_q == tfcc_pkg::MARKER_POS;

	// At most one add per byte: a completed pair, or at frame end the odd byte padded
	// with zero; a byte still held when the offset moves past the frame is
	// flushed the same way
	assign do_add  = last_byte ? (covered || odd_q) : (covered && odd_q);
	assign word    = odd_q ? {held_q, covered ? frame_byte : 8'h00} : {frame_byte, 8'h00};
	assign raw_sum = {1'b0, acc_q} + {1'b0, word};
	assign folded  = raw_sum[15:0] + {15'd0, raw_sum[16]};
	assign acc_next = do_add ? folded : acc_q;

	always_comb begin
		summary.sum    = ~acc_next;
		summary.seen   = seen_q || at_marker;
		summary.marker = at_marker ? frame_byte : marker_q;
	end

	// Frame state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			acc_q    <= '0;
			odd_q    <= 1'b0;
			held_q   <= '0;
			marker_q <= '0;
			seen_q   <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				pos_q    <= '0;
				acc_q    <= '0;
				odd_q    <= 1'b0;
				held_q   <= '0;
				marker_q <= '0;
				seen_q   <= 1'b0;
			end else begin
				if (pos_q != tfcc_pkg::POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				if (at_marker) begin
					marker_q <= frame_byte;
					seen_q   <= 1'b1;
				end
				if (covered) begin
					odd_q <= ~odd_q;
					if (!odd_q) begin
						held_q <= frame_byte;
					end
				end
				acc_q <= acc_next;
			end
		end
	end

endmodule

// ===== src/test_frame_checksum_checker.sv =====
// Channel   Handshake            Payload
// input     in_valid/in_ready    frame_byte, last_byte
// output    out_valid/out_ready  direction, checksum_bad, computed_sum,
//                                received_total, error_total
// config    cfg_write            cfg_index, cfg_data
//
// One byte per cycle sustained, unless a last byte waits on a held result.
// A byte is registered in the input register and then folded into the
// running sum register when it advances; the last byte of a frame also
// writes the result register. Non-last bytes never stall on the output; a
// last byte waits only while a previous result is still held. Reset clears
// the accumulator frame state, the counters and the registers to their defaults.
module test_frame_checksum_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [tfcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfcc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      frame_byte,
	input  logic                            last_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      direction,
	output logic                            checksum_bad,
	output logic [15:0]                     computed_sum,
	output logic [31:0]                     received_total,
	output logic [31:0]                     error_total
);

	logic [15:0] exp0_q;
	logic [15:0] exp1_q;
	logic [7:0]  mark0_q;
	logic [7:0]  mark1_q;
	logic [5:0]  offset_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	logic        load;

	logic [31:0] rx_cnt_q [2];
	logic [31:0] err_cnt_q [2];

	logic        out_valid_q;
	logic [1:0]  dir_q;
	logic        bad_q;
	logic [15:0] sum_q;
	logic [31:0] rx_q;
	logic [31:0] err_q;

	tfcc_pkg::frame_sum_t summary;
	logic [1:0]  dir;
	logic        matched;
	logic        sel;
	logic        bad;
	logic [31:0] rx_next;
	logic [31:0] err_next;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp0_q   <= tfcc_pkg::EXPECTED_SUM_RST;
			exp1_q   <= tfcc_pkg::EXPECTED_SUM_RST;
			mark0_q  <= tfcc_pkg::MARKER_DIR0_RST;
			mark1_q  <= tfcc_pkg::MARKER_DIR1_RST;
			offset_q <= tfcc_pkg::SUM_OFFSET_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				tfcc_pkg::REG_EXPECTED_SUM_DIR0: exp0_q   <= cfg_data;
				tfcc_pkg::REG_EXPECTED_SUM_DIR1: exp1_q   <= cfg_data;
				tfcc_pkg::REG_MARKER_DIR0:       mark0_q  <= cfg_data[7:0];
				tfcc_pkg::REG_MARKER_DIR1:       mark1_q  <= cfg_data[7:0];
				tfcc_pkg::REG_SUM_START_OFFSET:  offset_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Flow control: a last byte needs a free result slot
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign load     = advance && last_s1;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= frame_byte;
			last_s1 <= last_byte;
		end
	end

	tfcc_frame_acc u_acc (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.frame_byte       (byte_s1),
		.last_byte        (last_s1),
		.sum_start_offset (offset_q),
		.summary          (summary)
	);

	// Direction lookup; direction zero wins when both markers match
	always_comb begin
		if (summary.seen && summary.marker == mark0_q) begin
			dir = tfcc_pkg::DIR_ZERO;
		end else if (summary.seen && summary.marker == mark1_q) begin
			dir = tfcc_pkg::DIR_ONE;
		end else begin
			dir = tfcc_pkg::DIR_NONE;
		end
	end

	assign matched  = dir != tfcc_pkg::DIR_NONE;
	assign sel      = dir == tfcc_pkg::DIR_ONE;
	assign bad      = matched && (summary.sum != (sel ? exp1_q : exp0_q));
	assign rx_next  = rx_cnt_q[sel] + 32'd1;
	assign err_next = err_cnt_q[sel] + {31'd0, bad};

	// Per-direction counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_cnt_q[0]  <= '0;
			rx_cnt_q[1]  <= '0;
			err_cnt_q[0] <= '0;
			err_cnt_q[1] <= '0;
		end else if (load && matched) begin
			rx_cnt_q[sel]  <= rx_next;
			err_cnt_q[sel] <= err_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dir_q <= dir;
			bad_q <= bad;
			sum_q <= summary.sum;
			rx_q  <= matched ? rx_next : 32'd0;
			err_q <= matched ? err_next : 32'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign direction      = dir_q;
	assign checksum_bad   = bad_q;
	assign computed_sum   = sum_q;
	assign received_total = rx_q;
	assign error_total    = err_q;

	// Checks
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> last_s1 && valid_s1)
		else $error("result loaded from a byte that does not end a frame");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && dir_q == tfcc_pkg::DIR_NONE |->
			!bad_q && rx_q == 32'd0 && err_q == 32'd0)
		else $error("unmatched frame reported counters or error");

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		load && matched |=> out_valid_q && rx_q == $past(rx_cnt_q[sel]) + 32'd1)
		else $error("receive counter did not advance by one");

endmodule
